/* rtl/mrc_pkg.sv */
// Shared constants, types and the CRC byte update for the Modbus RTU response checker.
package mrc_pkg;

   localparam int MAX_FRAME = 256;
   localparam int SAT_COUNT = MAX_FRAME + 1;
   localparam int MIN_FRAME = 1 + 1 + 1 + 2;
   localparam int COUNT_W   = $clog2(SAT_COUNT + 1);
   localparam int CMP_W     = (COUNT_W > 8) ? COUNT_W + 1 : 9;

   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE = 8'h06;
   localparam int          EXC_BIT    = 7;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   typedef enum logic [2:0] {
      CLASS_READ_OK  = 3'd0,
      CLASS_WRITE    = 3'd1,
      CLASS_EXCEPT   = 3'd2,
      CLASS_UNKNOWN  = 3'd3,
      CLASS_MISMATCH = 3'd4
   } class_type;

   typedef struct packed {
      logic        item_kind;
      logic [6:0]  reg_index;
      logic [15:0] reg_word;
      logic [7:0]  device_addr;
      logic [7:0]  func_code;
      class_type   frame_class;
      logic        crc_bad;
      logic        length_bad;
      logic [8:0]  frame_length;
   } rsp_type;

   // Reflected CRC-16 update over one byte, LSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

/* rtl/mrc_frame_core.sv */
// Per-frame state, CRC accumulation and result formation for each received byte.
module mrc_frame_core
   import mrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       last_byte,
   output logic       result_valid,
   output rsp_type    result
);

   logic [15:0]        crc_ff,     crc_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic [7:0]         dly0_ff,    dly0_in;
   logic [7:0]         dly1_ff,    dly1_in;
   logic [7:0]         addr_ff,    addr_in;
   logic [7:0]         func_ff,    func_in;
   logic [7:0]         decl_ff,    decl_in;
   logic [7:0]         pend_ff,    pend_in;

   logic [15:0]        crc_cur;
   logic [COUNT_W-1:0] total;
   logic [COUNT_W-1:0] word_off;
   logic [CMP_W-1:0]   word_twice;
   logic [CMP_W-1:0]   decl_ext;
   logic [15:0]        trailing;
   logic               in_data;
   logic               word_hit;
   class_type          cls;

   always_comb begin
      crc_cur  = (count_ff >= COUNT_W'(2)) ? crc_feed(crc_ff, dly1_ff) : crc_ff;
      total    = (count_ff < COUNT_W'(SAT_COUNT)) ? count_ff + COUNT_W'(1)
                                                  : COUNT_W'(SAT_COUNT);
      addr_in  = (count_ff == COUNT_W'(0)) ? rx_byte : addr_ff;
      func_in  = (count_ff == COUNT_W'(1)) ? rx_byte : func_ff;
      decl_in  = (count_ff == COUNT_W'(2)) ? rx_byte : decl_ff;
      in_data  = (func_in == FUNC_READ) && (count_ff >= COUNT_W'(3))
                 && (count_ff < COUNT_W'(SAT_COUNT));
      pend_in  = (in_data && count_ff[0]) ? rx_byte : pend_ff;

      // word index k = (p - 4) / 2, compared as 2k against the declared count
      word_off   = count_ff - COUNT_W'(4);
      word_twice = CMP_W'({word_off[COUNT_W-1:1], 1'b0});
      decl_ext   = CMP_W'(decl_in);
      word_hit   = in_data && !count_ff[0] && (word_twice < decl_ext) && !last_byte;

      trailing = {rx_byte, dly0_ff};

      if (func_in[EXC_BIT]) begin
         cls = CLASS_EXCEPT;
      end else if (func_in == FUNC_READ) begin
         cls = ((total < COUNT_W'(SAT_COUNT))
                && (CMP_W'(total) == decl_ext + CMP_W'(MIN_FRAME))) ? CLASS_READ_OK
                                                                      : CLASS_MISMATCH;
      end else if (func_in == FUNC_WRITE) begin
         cls = CLASS_WRITE;
      end else begin
         cls = CLASS_UNKNOWN;
      end

      result = '0;
      if (last_byte) begin
         result.item_kind    = 1'b1;
         result.device_addr  = addr_in;
         result.func_code    = func_in;
         result.frame_class  = cls;
         result.crc_bad      = (crc_cur != trailing);
         result.length_bad   = (total < COUNT_W'(MIN_FRAME)) || (total > COUNT_W'(MAX_FRAME));
         result.frame_length = 9'(total);
      end else begin
         result.item_kind = 1'b0;
         result.reg_index = 7'(word_off[COUNT_W-1:1]);
         result.reg_word  = {pend_ff, rx_byte};
      end
      result_valid = last_byte || word_hit;

      // next state: closing byte clears the frame
      if (last_byte) begin
         crc_in   = CRC_INIT;
         count_in = '0;
         dly0_in  = '0;
         dly1_in  = '0;
      end else begin
         crc_in   = crc_cur;
         count_in = total;
         dly0_in  = rx_byte;
         dly1_in  = dly0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
         dly0_ff  <= '0;
         dly1_ff  <= '0;
         addr_ff  <= '0;
         func_ff  <= '0;
         decl_ff  <= '0;
         pend_ff  <= '0;
      end else if (accept) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         dly0_ff  <= dly0_in;
         dly1_ff  <= dly1_in;
         if (last_byte) begin
            addr_ff <= '0;
            func_ff <= '0;
            decl_ff <= '0;
            pend_ff <= '0;
         end else begin
            addr_ff <= addr_in;
            func_ff <= func_in;
            decl_ff <= decl_in;
            pend_ff <= pend_in;
         end
      end
   end

endmodule

/* rtl/mrc_out_stage.sv */
// Result register that holds one result until the downstream transfer completes.
module mrc_out_stage
   import mrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   always_comb begin
      can_load = !valid_ff || out_ready;
      valid_in = can_load ? load_valid : valid_ff;
      data_in  = (can_load && load_valid) ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/modbus_rtu_response_checker.sv */
// Modbus RTU response checker: CRC-16 check, register word extraction, frame status.
// A result appears on rsp_valid in the cycle after the byte transfer that causes it.
// Throughput: one byte per cycle while req_ready is high; the CRC byte update and classification are combinational.
// A held result does not stall input as long as rsp_ready is high in the same cycle.
// Reset (synchronous, active high) sets the CRC to 0xFFFF, clears the frame state
// and drops any result still held.
module modbus_rtu_response_checker
   import mrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_item_kind,
   output logic [6:0] rsp_reg_index,
   output logic [15:0] rsp_reg_word,
   output logic [7:0] rsp_device_addr,
   output logic [7:0] rsp_func_code,
   output logic [2:0] rsp_frame_class,
   output logic       rsp_crc_bad,
   output logic       rsp_length_bad,
   output logic [8:0] rsp_frame_length
);

   logic    accept;
   logic    can_load;
   logic    result_valid;
   rsp_type result;
   rsp_type out_data;

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   mrc_frame_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .last_byte    (req_last_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   mrc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept && result_valid),
      .load_data  (result),
      .can_load   (can_load),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_item_kind    = out_data.item_kind;
   assign rsp_reg_index    = out_data.reg_index;
   assign rsp_reg_word     = out_data.reg_word;
   assign rsp_device_addr  = out_data.device_addr;
   assign rsp_func_code    = out_data.func_code;
   assign rsp_frame_class  = out_data.frame_class;
   assign rsp_crc_bad      = out_data.crc_bad;
   assign rsp_length_bad   = out_data.length_bad;
   assign rsp_frame_length = out_data.frame_length;

endmodule

/* tb/mrc_response_check.sv */
// CRC helper and the response checker that predicts and compares the block's results.
package mrc_tb_crc_pkg;
   import mrc_pkg::*;

   // One byte through the reflected Modbus CRC-16, LSB first.
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] c;
      c = acc ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction
endpackage

module mrc_response_check
   import mrc_pkg::*;
   import mrc_tb_crc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_item_kind,
   input  logic [6:0]  rsp_reg_index,
   input  logic [15:0] rsp_reg_word,
   input  logic [7:0]  rsp_device_addr,
   input  logic [7:0]  rsp_func_code,
   input  logic [2:0]  rsp_frame_class,
   input  logic        rsp_crc_bad,
   input  logic        rsp_length_bad,
   input  logic [8:0]  rsp_frame_length,
   output int          fail_count,
   output int          pending_items,
   output int          words_checked,
   output int          frames_checked,
   output int          crc_flags,
   output int          len_flags
);

   // frame decode state
   logic [15:0] crc_run;
   logic [8:0]  byte_pos;
   logic [7:0]  newer_byte;
   logic [7:0]  older_byte;
   logic [7:0]  hdr_addr;
   logic [7:0]  hdr_func;
   logic [7:0]  hdr_count;
   logic [7:0]  word_high;

   rsp_type decoded_items[$];
   int      errors;
   int      n_words;
   int      n_frames;
   int      n_crc;
   int      n_len;

   task automatic clear_frame_state();
      crc_run    = CRC_INIT;
      byte_pos   = '0;
      newer_byte = '0;
      older_byte = '0;
      hdr_addr   = '0;
      hdr_func   = '0;
      hdr_count  = '0;
      word_high  = '0;
   endtask

   task automatic report_error(input string msg);
      errors++;
      $display("[%0t] ERROR %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want, input logic kind);
      if (got !== want)
         report_error($sformatf("%s item: %s got 0x%0h expected 0x%0h",
                                kind ? "status" : "word", name, got, want));
   endtask

   task automatic decode_frame_byte(input logic [7:0] b, input logic last);
      logic [8:0]  total;
      logic [15:0] trailing;
      int          widx;
      rsp_type     item;
      // the CRC trails the data by two bytes
      if (byte_pos >= 2) crc_run = crc16_step(crc_run, older_byte);
      total = (byte_pos < SAT_COUNT) ? byte_pos + 9'd1 : 9'(SAT_COUNT);

      if (byte_pos == 0) hdr_addr = b;
      else if (byte_pos == 1) hdr_func = b;
      else if (byte_pos == 2) hdr_count = b;

      if (hdr_func == FUNC_READ && byte_pos >= 3 && byte_pos < SAT_COUNT) begin
         if (byte_pos[0]) begin
            word_high = b;
         end else begin
            widx = (int'(byte_pos) - 4) / 2;
            // a word landing on the closing byte is dropped
            if (2 * widx < int'(hdr_count) && !last) begin
               item           = '0;
               item.reg_index = 7'(widx);
               item.reg_word  = {word_high, b};
               decoded_items.push_back(item);
            end
         end
      end

      if (last) begin
         trailing       = {b, newer_byte};
         item           = '0;
         item.item_kind = 1'b1;
         item.device_addr = hdr_addr;
         item.func_code   = hdr_func;
         if (hdr_func[EXC_BIT])
            item.frame_class = CLASS_EXCEPT;
         else if (hdr_func == FUNC_READ)
            item.frame_class = (total < SAT_COUNT && total == hdr_count + MIN_FRAME) ?
                               CLASS_READ_OK : CLASS_MISMATCH;
         else if (hdr_func == FUNC_WRITE)
            item.frame_class = CLASS_WRITE;
         else
            item.frame_class = CLASS_UNKNOWN;
         item.crc_bad      = (crc_run != trailing);
         item.length_bad   = (total < MIN_FRAME || total > MAX_FRAME);
         item.frame_length = total;
         decoded_items.push_back(item);
         clear_frame_state();
      end else begin
         older_byte = newer_byte;
         newer_byte = b;
         byte_pos   = total;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (decoded_items.size() == 0) begin
         report_error($sformatf("result with nothing expected (kind %0d)", rsp_item_kind));
         return;
      end
      want = decoded_items.pop_front();
      compare_field("item_kind", 16'(rsp_item_kind), 16'(want.item_kind), want.item_kind);
      compare_field("reg_index", 16'(rsp_reg_index), 16'(want.reg_index), want.item_kind);
      compare_field("reg_word", rsp_reg_word, want.reg_word, want.item_kind);
      compare_field("device_addr", 16'(rsp_device_addr), 16'(want.device_addr),
                    want.item_kind);
      compare_field("func_code", 16'(rsp_func_code), 16'(want.func_code), want.item_kind);
      compare_field("frame_class", 16'(rsp_frame_class), 16'(want.frame_class),
                    want.item_kind);
      compare_field("crc_bad", 16'(rsp_crc_bad), 16'(want.crc_bad), want.item_kind);
      compare_field("length_bad", 16'(rsp_length_bad), 16'(want.length_bad), want.item_kind);
      compare_field("frame_length", 16'(rsp_frame_length), 16'(want.frame_length),
                    want.item_kind);
      if (want.item_kind) begin
         n_frames++;
         if (want.crc_bad) n_crc++;
         if (want.length_bad) n_len++;
      end else begin
         n_words++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame_state();
         decoded_items.delete();
         errors   = 0;
         n_words  = 0;
         n_frames = 0;
         n_crc    = 0;
         n_len    = 0;
      end else begin
         // predict first: a result never leaves on the edge of its own byte
         if (req_valid && req_ready) decode_frame_byte(req_rx_byte, req_last_byte);
         if (rsp_valid && rsp_ready) check_result();
      end
      fail_count     <= errors;
      pending_items  <= decoded_items.size();
      words_checked  <= n_words;
      frames_checked <= n_frames;
      crc_flags      <= n_crc;
      len_flags      <= n_len;
   end

endmodule

/* tb/modbus_rtu_response_checker_tb.sv */
// Top of the Modbus RTU response checker testbench: clock, reset, frame stimulus, verdict.
module modbus_rtu_response_checker_tb;
   import mrc_pkg::*;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte   = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic        rsp_item_kind;
   logic [6:0]  rsp_reg_index;
   logic [15:0] rsp_reg_word;
   logic [7:0]  rsp_device_addr;
   logic [7:0]  rsp_func_code;
   logic [2:0]  rsp_frame_class;
   logic        rsp_crc_bad;
   logic        rsp_length_bad;
   logic [8:0]  rsp_frame_length;

   int fail_count;
   int pending_items;
   int words_checked;
   int frames_checked;
   int crc_flags;
   int len_flags;

   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   int         bytes_sent    = 0;
   logic [7:0] frame_buf[$];

   modbus_rtu_response_checker u_dut (.*);
   mrc_response_check u_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   initial begin
      #(8 * 400000);
      $display("timeout: run did not finish");
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= b;
      req_last_byte <= last;
      // hold until the transfer
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic append_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc_feed(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic build_read_frame(input int declared, input int payload_bytes);
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(FUNC_READ);
      frame_buf.push_back(8'(declared));
      repeat (payload_bytes) frame_buf.push_back(8'($urandom));
      append_crc();
   endtask

   task automatic build_small_frame();
      int         pick;
      int         declared;
      int         payload_bytes;
      int         pos;
      int         cut;
      logic [7:0] fc;
      pick = $urandom_range(99);
      if (pick < 60) begin
         declared = $urandom_range(24);
         if ($urandom_range(3) != 0) declared = declared & ~1;
         payload_bytes = declared;
         if ($urandom_range(9) == 0) payload_bytes = declared + $urandom_range(3, 1);
         else if ($urandom_range(9) == 0 && declared > 2)
            payload_bytes = declared - $urandom_range(2, 1);
         build_read_frame(declared, payload_bytes);
      end else begin
         frame_buf.delete();
         frame_buf.push_back(8'($urandom));
         if (pick < 70) begin
            frame_buf.push_back(FUNC_WRITE);
            repeat (4) frame_buf.push_back(8'($urandom));
         end else if (pick < 78) begin
            fc = 8'($urandom);
            fc[EXC_BIT] = 1'b1;
            frame_buf.push_back(fc);
            frame_buf.push_back(8'($urandom));
         end else if (pick < 85) begin
            frame_buf.push_back(8'($urandom));
            repeat ($urandom_range(6)) frame_buf.push_back(8'($urandom));
         end else begin
            // noise: no CRC, often claiming a read
            frame_buf.push_back(($urandom_range(1) == 0) ? FUNC_READ : 8'($urandom));
            repeat ($urandom_range(10)) frame_buf.push_back(8'($urandom));
            if ($urandom_range(5) == 0)
               while (frame_buf.size() > 1) void'(frame_buf.pop_back());
         end
         if (pick < 85) append_crc();
      end
      if (pick < 85 && $urandom_range(99) < 12) begin
         pos = $urandom_range(frame_buf.size() - 1);
         frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(7));
      end
      // cut some reads short
      if (pick >= 50 && pick < 60) begin
         cut = $urandom_range(frame_buf.size() - 1, 1);
         while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
   endtask

   initial begin
      int idle_plan[4]  = '{0, 77, 0, 11};
      int stall_plan[4] = '{0, 0, 77, 11};
      int target;
      int guard;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single byte: header, CRC and count all short
      frame_buf = '{8'h00};
      send_frame();
      frame_buf = '{8'hFF, 8'hFF};
      send_frame();
      frame_buf = '{8'hFF, FUNC_READ | 8'h80, 8'h02};
      append_crc();
      send_frame();
      frame_buf = '{8'h01, FUNC_WRITE, 8'h00, 8'h01, 8'hFF, 8'hFE};
      append_crc();
      send_frame();
      // odd byte count: the last word takes the CRC low byte
      frame_buf = '{8'h11, FUNC_READ, 8'h01, 8'hAB};
      append_crc();
      send_frame();
      frame_buf = '{8'h7F, 8'h42, 8'h00};
      send_frame();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph];
         stall_pct     = stall_plan[ph];
         target        = 25 + 1325 * (ph + 1) / 4;
         // largest legal read, then an overlong one that saturates the count
         if (ph == 1) begin
            build_read_frame(251, 251);
            send_frame();
         end
         if (ph == 3) begin
            build_read_frame(255, 258);
            send_frame();
         end
         while (bytes_sent < target) begin
            build_small_frame();
            send_frame();
         end
      end
      req_valid <= 1'b0;

      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_items != 0 && guard < 20000);
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes under free-running, sender-gap, receiver-stall and mixed pacing.",
               bytes_sent);
      $display("Checked %0d register words and %0d frame status items (%0d CRC, %0d length errors).",
               words_checked, frames_checked, crc_flags, len_flags);
      if (pending_items != 0) $display("%0d expected results never arrived", pending_items);
      if (fail_count == 0 && pending_items == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
